>>> hdl/tnbc_pkg.sv
// shared types, constants and helpers of the triple notch biquad cascade
package tnbc_pkg;

	localparam int RAW_W      = 12;
	localparam int IDX_W      = 32;
	localparam int OUT_W      = 16;
	localparam int COEF_W     = 32;
	localparam int A2_W       = 34;
	localparam int VAL_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_NOTCH  = 3;
	localparam int FRAC_BITS  = 20;
	localparam int COEF_SHIFT = 30;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOTCH1_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOTCH1_COS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOTCH2_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOTCH2_COS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NOTCH3_GAIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NOTCH3_COS    = 3'd6;

	localparam logic [CFG_IDX_W-1:0] GAIN_REG [NUM_NOTCH] =
		'{REG_NOTCH1_GAIN, REG_NOTCH2_GAIN, REG_NOTCH3_GAIN};
	localparam logic [CFG_IDX_W-1:0] COS_REG [NUM_NOTCH] =
		'{REG_NOTCH1_COS, REG_NOTCH2_COS, REG_NOTCH3_COS};

	// reset values
	localparam logic [RAW_W-1:0] CENTER_OFFSET_RST = 12'd2048;
	localparam logic signed [COEF_W-1:0] GAIN_RST [NUM_NOTCH] =
		'{32'sd1062613752, 32'sd1051711606, 32'sd1041026256};
	localparam logic signed [COEF_W-1:0] COS_RST [NUM_NOTCH] =
		'{-32'sd2021211467, -32'sd1701705126, -32'sd1223799761};

	// 1.0 in q4.30, used for a2 = 2*b0 - 1
	localparam logic signed [A2_W-1:0] ONE_Q30 = 34'sd1073741824;

	localparam logic signed [VAL_W-1:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [VAL_W-1:0] I64_MIN = 64'sh8000_0000_0000_0000;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [COEF_W-1:0] gain;
		logic signed [COEF_W-1:0] cos_term;
	} coef_t;

	typedef struct packed {
		logic                    start;
		logic signed [A2_W-1:0]  coef;
		logic signed [VAL_W-1:0] val;
	} mul_req_t;

	typedef enum logic [2:0] {
		MUL_IDLE,
		MUL_LO,
		MUL_HI,
		MUL_ACC,
		MUL_RND,
		MUL_SGN
	} mul_state_t;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_LOAD,
		SEQ_BX_GO,
		SEQ_BX_WAIT,
		SEQ_Y,
		SEQ_B1X_GO,
		SEQ_B1X_WAIT,
		SEQ_AY1_GO,
		SEQ_AY1_WAIT,
		SEQ_Z1,
		SEQ_AY2_GO,
		SEQ_AY2_WAIT,
		SEQ_ROUND,
		SEQ_EMIT
	} seq_state_t;

	// clamp a widened sum to the signed 64-bit range
	function automatic logic signed [VAL_W-1:0] sat64(input logic signed [VAL_W+1:0] v);
		logic signed [VAL_W+1:0] hi;
		logic signed [VAL_W+1:0] lo;
		hi = (VAL_W+2)'(I64_MAX);
		lo = (VAL_W+2)'(I64_MIN);
		if (v > hi) begin
			return I64_MAX;
		end else if (v < lo) begin
			return I64_MIN;
		end
		return VAL_W'(v);
	endfunction

endpackage

>>> hdl/tnbc_if.sv
// item channels of the notch cascade: sample input and filtered result output
interface tnbc_in_if;
	logic                          valid;
	logic                          ready;
	logic [tnbc_pkg::RAW_W-1:0]    raw_sample;
	logic [tnbc_pkg::IDX_W-1:0]    sample_index;

	modport source (output valid, output raw_sample, output sample_index, input ready);
	modport sink (input valid, input raw_sample, input sample_index, output ready);
endinterface

interface tnbc_out_if;
	logic                              valid;
	logic                              ready;
	logic [tnbc_pkg::RAW_W-1:0]        raw_out;
	logic signed [tnbc_pkg::OUT_W-1:0] filtered_out;
	logic [tnbc_pkg::IDX_W-1:0]        index_out;

	modport source (output valid, output raw_out, output filtered_out, output index_out,
		input ready);
	modport sink (input valid, input raw_out, input filtered_out, input index_out,
		output ready);
endinterface

>>> hdl/tnbc_cfg.sv
// configuration registers and per-section coefficient select
module tnbc_cfg #(
	parameter int STAGE_COUNT = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [tnbc_pkg::CFG_IDX_W-1:0]      index,
	input  logic [tnbc_pkg::CFG_DATA_W-1:0]     wdata,
	input  logic [(STAGE_COUNT > 1 ? $clog2(STAGE_COUNT) : 1)-1:0] stage,
	output logic [tnbc_pkg::RAW_W-1:0]          center_offset,
	output tnbc_pkg::coef_t                     coef
);

	logic [tnbc_pkg::RAW_W-1:0]         offset_q;
	logic signed [tnbc_pkg::COEF_W-1:0] gain_q [tnbc_pkg::NUM_NOTCH];
	logic signed [tnbc_pkg::COEF_W-1:0] cos_q  [tnbc_pkg::NUM_NOTCH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= tnbc_pkg::CENTER_OFFSET_RST;
			for (int s = 0; s < tnbc_pkg::NUM_NOTCH; s++) begin
				gain_q[s] <= tnbc_pkg::GAIN_RST[s];
				cos_q[s]  <= tnbc_pkg::COS_RST[s];
			end
		end else if (wr_en) begin
			if (index == tnbc_pkg::REG_CENTER_OFFSET) begin
				offset_q <= wdata[tnbc_pkg::RAW_W-1:0];
			end
			for (int s = 0; s < tnbc_pkg::NUM_NOTCH; s++) begin
				if (index == tnbc_pkg::GAIN_REG[s]) begin
					gain_q[s] <= $signed(wdata);
				end
				if (index == tnbc_pkg::COS_REG[s]) begin
					cos_q[s] <= $signed(wdata);
				end
			end
		end
	end

	// sections past the configurable ones see zero coefficients
	always_comb begin
		coef = '0;
		for (int s = 0; s < tnbc_pkg::NUM_NOTCH; s++) begin
			if (int'(stage) == s) begin
				coef.gain     = gain_q[s];
				coef.cos_term = cos_q[s];
			end
		end
	end

	assign center_offset = offset_q;

endmodule

>>> hdl/tnbc_qmul.sv
// shared q2.30 product unit: c*v/2^30 rounded half away from zero, two 34x32 passes
module tnbc_qmul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tnbc_pkg::mul_req_t                  req,
	output logic                                done,
	output logic signed [tnbc_pkg::VAL_W-1:0]   result
);

	localparam int AW    = tnbc_pkg::A2_W;
	localparam int VW    = tnbc_pkg::VAL_W;
	localparam int HW    = VW / 2;
	localparam int PW    = AW + HW;
	localparam int ACC_W = AW + VW;
	localparam int RW    = ACC_W - tnbc_pkg::COEF_SHIFT;
	localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (tnbc_pkg::COEF_SHIFT - 1);

	tnbc_pkg::mul_state_t state_q, state_d;

	logic             neg_q;
	logic [AW-1:0]    cm_q;
	logic [VW-1:0]    vm_q;
	logic [PW-1:0]    prod_q;
	logic [ACC_W-1:0] acc_q;
	logic [VW-2:0]    mag_q;
	logic [ACC_W-1:0] rsum;
	logic [RW-1:0]    rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tnbc_pkg::MUL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		unique case (state_q)
			tnbc_pkg::MUL_IDLE: begin
				if (req.start) begin
					state_d = tnbc_pkg::MUL_LO;
				end
			end
			tnbc_pkg::MUL_LO:  state_d = tnbc_pkg::MUL_HI;
			tnbc_pkg::MUL_HI:  state_d = tnbc_pkg::MUL_ACC;
			tnbc_pkg::MUL_ACC: state_d = tnbc_pkg::MUL_RND;
			tnbc_pkg::MUL_RND: state_d = tnbc_pkg::MUL_SGN;
			tnbc_pkg::MUL_SGN: begin
				done    = 1'b1;
				state_d = tnbc_pkg::MUL_IDLE;
			end
			default: state_d = tnbc_pkg::MUL_IDLE;
		endcase
	end

	assign rsum = acc_q + HALF_LSB;
	assign rnd  = RW'(rsum >> tnbc_pkg::COEF_SHIFT);

	// sign-magnitude datapath, one multiply per cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			tnbc_pkg::MUL_IDLE: begin
				if (req.start) begin
					neg_q <= req.coef[AW-1] ^ req.val[VW-1];
					cm_q  <= req.coef[AW-1] ? AW'(-req.coef) : AW'(req.coef);
					vm_q  <= req.val[VW-1] ? VW'(-req.val) : VW'(req.val);
				end
			end
			tnbc_pkg::MUL_LO: begin
				prod_q <= PW'(cm_q * vm_q[HW-1:0]);
			end
			tnbc_pkg::MUL_HI: begin
				acc_q  <= ACC_W'(prod_q);
				prod_q <= PW'(cm_q * vm_q[VW-1:HW]);
			end
			tnbc_pkg::MUL_ACC: begin
				acc_q <= acc_q + (ACC_W'(prod_q) << HW);
			end
			tnbc_pkg::MUL_RND: begin
				// clamp the magnitude at the signed 64-bit maximum
				if (|rnd[RW-1:VW-1]) begin
					mag_q <= '1;
				end else begin
					mag_q <= rnd[VW-2:0];
				end
			end
			tnbc_pkg::MUL_SGN: begin
			end
			default: begin
			end
		endcase
	end

	assign result = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

>>> hdl/triple_notch_biquad_cascade.sv
// top level of the triple notch biquad cascade: sequencer, state and output register
//
// usage
// - samples channel: valid/ready with raw_sample (12 bit adc code) and sample_index;
//   an item is taken when valid and ready are both high
// - results channel: valid/ready with raw_out, filtered_out (signed 16 bit) and
//   index_out; exactly one result item per sample item, in order
// - cfg port: write enable, register index and data, taken on any rising edge with the
//   enable high; write only while no item is in flight
// - timing: ready stays low after an item is taken until the sequencer is back in
//   idle, so a new item is taken only once the last one has left the sequencer; the
//   shared product unit runs 4 products per section, one after another, plus two
//   add/saturate steps
// - the result is loaded into the output register from the emit state, after the final rounding
// - reset clears the section delay state to zero, loads the default
//   coefficients and offset, and empties the output register
// - a stalled receiver holds the result in the output register; the next item is
//   still taken and processed, and its result waits until the held one leaves
module triple_notch_biquad_cascade #(
	parameter int STAGE_COUNT = 3,
	parameter int STATE_WIDTH = 48,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	tnbc_in_if.sink                             samples,
	tnbc_out_if.source                          results,
	input  logic                                cfg_wr_en,
	input  logic [tnbc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tnbc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int VW     = tnbc_pkg::VAL_W;
	localparam int WW     = VW + 2;
	localparam int AW     = tnbc_pkg::A2_W;
	localparam int RAW_W  = tnbc_pkg::RAW_W;
	localparam int IDX_W  = tnbc_pkg::IDX_W;
	localparam int OUT_W  = tnbc_pkg::OUT_W;
	localparam int FRAC   = tnbc_pkg::FRAC_BITS;
	localparam int STG_W  = STAGE_COUNT > 1 ? $clog2(STAGE_COUNT) : 1;
	localparam int SMP_W  = SAMPLE_BITS < RAW_W ? SAMPLE_BITS : RAW_W;
	localparam int MAG_RAW = STATE_WIDTH + 1 - FRAC;
	localparam int MAG_W  = MAG_RAW > OUT_W + 1 ? MAG_RAW : OUT_W + 1;
	localparam logic [STATE_WIDTH:0] RND_HALF = (STATE_WIDTH+1)'(1) << (FRAC - 1);

	// signed state range
	localparam logic signed [VW-1:0] ST_MAX = tnbc_pkg::I64_MAX >>> (VW - STATE_WIDTH);
	localparam logic signed [VW-1:0] ST_MIN = ~ST_MAX;

	function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [VW-1:0] v);
		if (v > ST_MAX) begin
			return STATE_WIDTH'(ST_MAX);
		end else if (v < ST_MIN) begin
			return STATE_WIDTH'(ST_MIN);
		end
		return STATE_WIDTH'(v);
	endfunction

	tnbc_pkg::seq_state_t state_q, state_d;

	logic [STG_W-1:0]              stage_q;
	logic                          out_valid_q;
	logic signed [STATE_WIDTH-1:0] z1_q [STAGE_COUNT];
	logic signed [STATE_WIDTH-1:0] z2_q [STAGE_COUNT];

	logic [SMP_W-1:0]              raw_in_q;
	logic [IDX_W-1:0]              idx_in_q;
	logic signed [STATE_WIDTH-1:0] x_q;
	logic signed [STATE_WIDTH-1:0] y_q;
	logic signed [VW-1:0]          bx_q;
	logic signed [VW-1:0]          t_q;
	logic [MAG_W-1:0]              mag_q;
	logic                          neg_q;

	logic [RAW_W-1:0]              raw_out_q;
	logic signed [OUT_W-1:0]       filt_q;
	logic [IDX_W-1:0]              idx_out_q;

	logic [RAW_W-1:0]              offset;
	tnbc_pkg::coef_t               coef;
	logic signed [AW-1:0]          a2;
	tnbc_pkg::mul_req_t            mul_req;
	logic                          mul_done;
	logic signed [VW-1:0]          mul_res;

	logic                          in_acc;
	logic                          emit_load;
	logic                          is_last;
	logic signed [SMP_W:0]         centered;
	logic signed [VW-1:0]          x_wide;
	logic signed [STATE_WIDTH:0]   y_ext;
	logic [STATE_WIDTH:0]          y_rnd;
	logic signed [OUT_W-1:0]       filt_d;

	tnbc_cfg #(
		.STAGE_COUNT (STAGE_COUNT)
	) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (cfg_wr_en),
		.index         (cfg_index),
		.wdata         (cfg_wdata),
		.stage         (stage_q),
		.center_offset (offset),
		.coef          (coef)
	);

	tnbc_qmul u_qmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.result (mul_res)
	);

	// a2 = 2*b0 - 1 in q4.30, exact at 34 bits
	assign a2 = (AW'($signed(coef.gain)) <<< 1) - tnbc_pkg::ONE_Q30;

	assign in_acc    = samples.valid && samples.ready;
	assign emit_load = (state_q == tnbc_pkg::SEQ_EMIT) && (!out_valid_q || results.ready);
	assign is_last   = stage_q == STG_W'(STAGE_COUNT - 1);

	// offset removal, then scale to 20 fraction bits
	assign centered = $signed({1'b0, raw_in_q}) - $signed({1'b0, offset[SMP_W-1:0]});
	assign x_wide   = VW'(centered) <<< FRAC;

	// final rounding: magnitude plus one half, drop the fraction
	assign y_ext = (STATE_WIDTH+1)'(x_q);
	assign y_rnd = (y_ext < 0 ? (STATE_WIDTH+1)'(-y_ext) : (STATE_WIDTH+1)'(y_ext)) + RND_HALF;

	always_comb begin
		if (neg_q) begin
			filt_d = (mag_q > MAG_W'(32768)) ? tnbc_pkg::OUT_MIN : -$signed(mag_q[OUT_W-1:0]);
		end else begin
			filt_d = (mag_q > MAG_W'(32767)) ? tnbc_pkg::OUT_MAX : $signed(mag_q[OUT_W-1:0]);
		end
	end

	// sequencer: per section bx, y, b1*x, b1*y, z1, a2*y and z2 in turn
	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		mul_req       = '0;
		unique case (state_q)
			tnbc_pkg::SEQ_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					state_d = tnbc_pkg::SEQ_LOAD;
				end
			end
			tnbc_pkg::SEQ_LOAD: state_d = tnbc_pkg::SEQ_BX_GO;
			tnbc_pkg::SEQ_BX_GO: begin
				mul_req.start = 1'b1;
				mul_req.coef  = AW'($signed(coef.gain));
				mul_req.val   = VW'(x_q);
				state_d       = tnbc_pkg::SEQ_BX_WAIT;
			end
			tnbc_pkg::SEQ_BX_WAIT: begin
				if (mul_done) begin
					state_d = tnbc_pkg::SEQ_Y;
				end
			end
			tnbc_pkg::SEQ_Y: state_d = tnbc_pkg::SEQ_B1X_GO;
			tnbc_pkg::SEQ_B1X_GO: begin
				mul_req.start = 1'b1;
				mul_req.coef  = AW'($signed(coef.cos_term));
				mul_req.val   = VW'(x_q);
				state_d       = tnbc_pkg::SEQ_B1X_WAIT;
			end
			tnbc_pkg::SEQ_B1X_WAIT: begin
				if (mul_done) begin
					state_d = tnbc_pkg::SEQ_AY1_GO;
				end
			end
			tnbc_pkg::SEQ_AY1_GO: begin
				mul_req.start = 1'b1;
				mul_req.coef  = AW'($signed(coef.cos_term));
				mul_req.val   = VW'(y_q);
				state_d       = tnbc_pkg::SEQ_AY1_WAIT;
			end
			tnbc_pkg::SEQ_AY1_WAIT: begin
				if (mul_done) begin
					state_d = tnbc_pkg::SEQ_Z1;
				end
			end
			tnbc_pkg::SEQ_Z1: state_d = tnbc_pkg::SEQ_AY2_GO;
			tnbc_pkg::SEQ_AY2_GO: begin
				mul_req.start = 1'b1;
				mul_req.coef  = a2;
				mul_req.val   = VW'(y_q);
				state_d       = tnbc_pkg::SEQ_AY2_WAIT;
			end
			tnbc_pkg::SEQ_AY2_WAIT: begin
				if (mul_done) begin
					state_d = is_last ? tnbc_pkg::SEQ_ROUND : tnbc_pkg::SEQ_BX_GO;
				end
			end
			tnbc_pkg::SEQ_ROUND: state_d = tnbc_pkg::SEQ_EMIT;
			tnbc_pkg::SEQ_EMIT: begin
				// wait here while the output register still holds an unread item
				if (!out_valid_q || results.ready) begin
					state_d = tnbc_pkg::SEQ_IDLE;
				end
			end
			default: state_d = tnbc_pkg::SEQ_IDLE;
		endcase
	end

	// control state and section delay registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tnbc_pkg::SEQ_IDLE;
			stage_q     <= '0;
			out_valid_q <= 1'b0;
			for (int s = 0; s < STAGE_COUNT; s++) begin
				z1_q[s] <= '0;
				z2_q[s] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == tnbc_pkg::SEQ_LOAD) begin
				stage_q <= '0;
			end else if (state_q == tnbc_pkg::SEQ_AY2_WAIT && mul_done && !is_last) begin
				stage_q <= STG_W'(stage_q + 1'b1);
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == tnbc_pkg::SEQ_Z1) begin
				z1_q[stage_q] <= sat_state(tnbc_pkg::sat64(WW'(t_q) + WW'(z2_q[stage_q])));
			end
			if (state_q == tnbc_pkg::SEQ_AY2_WAIT && mul_done) begin
				z2_q[stage_q] <= sat_state(tnbc_pkg::sat64(WW'(bx_q) - WW'(mul_res)));
			end
		end
	end

	// working values of the item in flight
	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_in_q <= SMP_W'(samples.raw_sample);
			idx_in_q <= samples.sample_index;
		end
		unique case (state_q)
			tnbc_pkg::SEQ_LOAD: begin
				x_q <= sat_state(x_wide);
			end
			tnbc_pkg::SEQ_BX_WAIT: begin
				if (mul_done) begin
					bx_q <= mul_res;
				end
			end
			tnbc_pkg::SEQ_Y: begin
				y_q <= sat_state(tnbc_pkg::sat64(WW'(bx_q) + WW'(z1_q[stage_q])));
			end
			tnbc_pkg::SEQ_B1X_WAIT: begin
				if (mul_done) begin
					t_q <= mul_res;
				end
			end
			tnbc_pkg::SEQ_AY1_WAIT: begin
				if (mul_done) begin
					t_q <= tnbc_pkg::sat64(WW'(t_q) - WW'(mul_res));
				end
			end
			tnbc_pkg::SEQ_AY2_WAIT: begin
				// section output feeds the next section
				if (mul_done) begin
					x_q <= y_q;
				end
			end
			tnbc_pkg::SEQ_ROUND: begin
				neg_q <= x_q < 0;
				mag_q <= MAG_W'(y_rnd >> FRAC);
			end
			default: begin
			end
		endcase
		if (emit_load) begin
			raw_out_q <= RAW_W'(raw_in_q);
			filt_q    <= filt_d;
			idx_out_q <= idx_in_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.raw_out      = raw_out_q;
	assign results.filtered_out = filt_q;
	assign results.index_out    = idx_out_q;

endmodule

>>> hdl/tnbc_checker.sv
// port-level checks of the notch cascade, bound to the top level
module tnbc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [tnbc_pkg::RAW_W-1:0]        raw_out,
	input logic signed [tnbc_pkg::OUT_W-1:0] filtered_out,
	input logic [tnbc_pkg::IDX_W-1:0]        index_out
);

	// an accepted item keeps the input side busy, with ready held low after the accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input taken again too soon after an item");

	// a new result only appears as the sequencer returns to idle
	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared while an item was in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(raw_out)
			&& $stable(filtered_out) && $stable(index_out))
		else $error("stalled result changed");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result withdrawn without being taken");

endmodule

bind triple_notch_biquad_cascade tnbc_checker u_tnbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (samples.valid),
	.in_ready     (samples.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.raw_out      (results.raw_out),
	.filtered_out (results.filtered_out),
	.index_out    (results.index_out)
);

>>> tb/sv/tb_triple_notch_biquad_cascade.sv
// self-checking testbench of the triple notch biquad cascade with a fixed-point predictor
module tb_triple_notch_biquad_cascade;
	import tnbc_pkg::*;

	// block configuration under test
	localparam int STAGES   = 3;
	localparam int STATE_W  = 48;
	localparam int SAMPLE_W = 12;

	// register index that maps to no register, writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// cycles without any item moving on either channel before the run is given up;
	// the limit must cover one item's processing plus a sender gap and a receiver stall
	localparam int STALL_LIMIT = 2000;

	// cycles of quiet after the last result before a register write
	localparam int SETTLE_CYCLES = 4;
	// cycles of quiet at the very end, a little more than one item's latency
	localparam int TAIL_CYCLES = 100;

	localparam longint STATE_MAX = (longint'(1) <<< (STATE_W - 1)) - 1;
	localparam longint STATE_MIN = -STATE_MAX - 1;

	// one result item as the block should emit it
	typedef struct packed {
		logic [RAW_W-1:0]        raw;
		logic signed [OUT_W-1:0] filtered;
		logic [IDX_W-1:0]        index;
	} filtered_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tnbc_in_if  samples_ch ();
	tnbc_out_if results_ch ();

	triple_notch_biquad_cascade #(
		.STAGE_COUNT(STAGES),
		.STATE_WIDTH(STATE_W),
		.SAMPLE_BITS(SAMPLE_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_ch),
		.results(results_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// 12 time unit period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor copy of the registers and of the section delay lines
	logic [RAW_W-1:0]         cur_offset;
	logic signed [COEF_W-1:0] cur_gain [NUM_NOTCH];
	logic signed [COEF_W-1:0] cur_cos [NUM_NOTCH];
	longint                   section_z1 [NUM_NOTCH];
	longint                   section_z2 [NUM_NOTCH];

	// results owed by the block, oldest first
	filtered_item_t pending_results [$];

	int unsigned sender_idle_pct;
	int unsigned receiver_idle_pct;
	int unsigned mismatch_count = 0;
	int unsigned results_seen = 0;
	int unsigned quiet_cycles = 0;

	// random sample source: a wandering level plus jumps and rail hits
	int          walk_level;
	logic [IDX_W-1:0] sample_seq;

	// ------------------------------------------------------------------
	// fixed-point predictor
	// ------------------------------------------------------------------

	function automatic logic signed [VAL_W+1:0] widen(longint v);
		return {{2{v[VAL_W-1]}}, v};
	endfunction

	// clamp a two-bit-wider sum into the 64-bit range
	function automatic longint clamp_wide(logic signed [VAL_W+1:0] w);
		if (w > widen(I64_MAX)) begin
			return I64_MAX;
		end
		if (w < widen(I64_MIN)) begin
			return I64_MIN;
		end
		return longint'(w[VAL_W-1:0]);
	endfunction

	function automatic longint clamp_add(longint a, longint b);
		return clamp_wide(widen(a) + widen(b));
	endfunction

	function automatic longint clamp_sub(longint a, longint b);
		return clamp_wide(widen(a) - widen(b));
	endfunction

	function automatic longint clamp_state(longint v);
		if (v > STATE_MAX) begin
			return STATE_MAX;
		end
		if (v < STATE_MIN) begin
			return STATE_MIN;
		end
		return v;
	endfunction

	// coefficient times value over 2^30, magnitude rounded half up, then signed
	function automatic longint notch_product(longint c, longint v);
		logic [63:0]  mc;
		logic [63:0]  mv;
		logic [127:0] p;
		logic         neg;
		longint       r;
		neg = (c < 0) != (v < 0);
		mc = (c < 0) ? -c : c;
		mv = (v < 0) ? -v : v;
		p = {64'd0, mc} * {64'd0, mv};
		p = (p + (128'd1 << (COEF_SHIFT - 1))) >> COEF_SHIFT;
		if (p > 128'h7FFF_FFFF_FFFF_FFFF) begin
			p = 128'h7FFF_FFFF_FFFF_FFFF;
		end
		r = longint'(p[63:0]);
		return neg ? -r : r;
	endfunction

	// one transposed direct form ii section, updates its delay line
	function automatic longint run_notch_section(int s, longint x);
		longint b0;
		longint b1;
		longint a2;
		longint bx;
		longint y;
		b0 = longint'(cur_gain[s]);
		b1 = longint'(cur_cos[s]);
		a2 = 2 * b0 - (longint'(1) <<< COEF_SHIFT);
		bx = notch_product(b0, x);
		y = clamp_state(clamp_add(bx, section_z1[s]));
		section_z1[s] = clamp_state(clamp_add(clamp_sub(notch_product(b1, x),
			notch_product(b1, y)), section_z2[s]));
		section_z2[s] = clamp_state(clamp_sub(bx, notch_product(a2, y)));
		return y;
	endfunction

	function automatic filtered_item_t filter_sample(logic [RAW_W-1:0] raw,
		logic [IDX_W-1:0] idx);
		filtered_item_t res;
		longint         v;
		logic [63:0]    m;
		longint         r;
		v = longint'({52'd0, raw}) - longint'({52'd0, cur_offset});
		v = clamp_state(v <<< FRAC_BITS);
		for (int s = 0; s < STAGES; s++) begin
			v = run_notch_section(s, v);
		end
		// round half away from zero to an integer, then to int16
		m = (v < 0) ? -v : v;
		m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (v < 0) begin
			r = (m > 64'd32768) ? -64'sd32768 : -longint'(m);
		end else begin
			r = (m > 64'd32767) ? 64'sd32767 : longint'(m);
		end
		res.raw = raw;
		res.filtered = r[OUT_W-1:0];
		res.index = idx;
		return res;
	endfunction

	function automatic void note_reg_write(logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DATA_W-1:0] data);
		if (idx == REG_CENTER_OFFSET) begin
			cur_offset = data[RAW_W-1:0];
		end
		for (int s = 0; s < NUM_NOTCH; s++) begin
			if (idx == GAIN_REG[s]) begin
				cur_gain[s] = data;
			end
			if (idx == COS_REG[s]) begin
				cur_cos[s] = data;
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// one sample item; valid stays high into the next call unless that call idles
	task automatic send_sample(input logic [RAW_W-1:0] raw, input logic [IDX_W-1:0] idx);
		if ($urandom_range(99) < sender_idle_pct) begin
			samples_ch.valid <= 1'b0;
			// short gaps or gaps as long as a whole item, so they hit every phase
			repeat (($urandom_range(1) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 100))
				@(posedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.raw_sample <= raw;
		samples_ch.sample_index <= idx;
		@(posedge clk);
		while (!samples_ch.ready) begin
			@(posedge clk);
		end
		pending_results.push_back(filter_sample(raw, idx));
	endtask

	// stop sending and let every owed result drain out
	task automatic wait_for_idle();
		samples_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		note_reg_write(idx, data);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_default_coefs();
		for (int s = 0; s < NUM_NOTCH; s++) begin
			write_reg(GAIN_REG[s], GAIN_RST[s]);
			write_reg(COS_REG[s], COS_RST[s]);
		end
	endtask

	function automatic logic [RAW_W-1:0] next_raw_sample();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 25) begin
			return RAW_W'($urandom_range(4095));
		end
		if (pick < 35) begin
			return ($urandom_range(1) != 0) ? {RAW_W{1'b1}} : {RAW_W{1'b0}};
		end
		walk_level = walk_level + int'($urandom_range(400)) - 200;
		if (walk_level < 0) begin
			walk_level = 0;
		end else if (walk_level > 4095) begin
			walk_level = 4095;
		end
		return RAW_W'(walk_level);
	endfunction

	// mostly a running count, now and then a jump
	function automatic logic [IDX_W-1:0] next_index();
		if ($urandom_range(9) == 0) begin
			sample_seq = $urandom();
		end else begin
			sample_seq = sample_seq + 1'b1;
		end
		return sample_seq;
	endfunction

	// new settings between bursts, only with the block idle
	task automatic reprogram_random();
		int unsigned pick;
		logic signed [COEF_W-1:0] jitter;
		pick = $urandom_range(9);
		wait_for_idle();
		if (pick <= 3) begin
			// offset near midscale, upper data bits are don't-care
			write_reg(REG_CENTER_OFFSET, {20'($urandom()), 12'($urandom_range(1800, 2300))});
		end else if (pick <= 6) begin
			// notches moved a little off their design frequencies
			for (int s = 0; s < NUM_NOTCH; s++) begin
				jitter = COEF_W'($urandom_range(8388608)) - 32'sd4194304;
				write_reg(GAIN_REG[s], GAIN_RST[s] + jitter);
				jitter = COEF_W'($urandom_range(8388608)) - 32'sd4194304;
				write_reg(COS_REG[s], COS_RST[s] + jitter);
			end
		end else if (pick == 7) begin
			// arbitrary registers with arbitrary data, the unused index included
			repeat ($urandom_range(1, 4))
				write_reg(CFG_IDX_W'($urandom_range(7)), $urandom());
		end else if (pick == 8) begin
			write_reg(REG_CENTER_OFFSET, CENTER_OFFSET_RST);
			write_default_coefs();
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset settings, field extremes and bit patterns
	task automatic test_default_extremes();
		send_sample(12'd0, 32'd0);
		send_sample(12'hFFF, 32'hFFFF_FFFF);
		send_sample(12'd2048, 32'h5555_5555);
		send_sample(12'd2047, 32'hAAAA_AAAA);
		send_sample(12'hFFF, 32'd1);
		send_sample(12'd0, 32'd2);
		send_sample(12'h555, 32'h8000_0000);
		send_sample(12'hAAA, 32'h7FFF_FFFF);
		wait_for_idle();
	endtask

	// offset at both ends, masking of wide offset data, unused index dropped
	task automatic test_offset_range();
		write_reg(REG_CENTER_OFFSET, 32'd0);
		send_sample(12'hFFF, 32'd10);
		send_sample(12'd0, 32'd11);
		wait_for_idle();
		write_reg(REG_CENTER_OFFSET, 32'd4095);
		send_sample(12'd0, 32'd12);
		send_sample(12'hFFF, 32'd13);
		wait_for_idle();
		// only the low 12 bits reach the offset
		write_reg(REG_CENTER_OFFSET, 32'hABCD_E7FF);
		send_sample(12'd2047, 32'd14);
		send_sample(12'hFFF, 32'd15);
		wait_for_idle();
		write_reg(REG_UNUSED, $urandom());
		send_sample(12'd100, 32'd16);
		wait_for_idle();
		write_reg(REG_CENTER_OFFSET, CENTER_OFFSET_RST);
	endtask

	// coefficient rails: unstable sections drive the state and output into saturation
	task automatic test_coef_extremes();
		for (int s = 0; s < NUM_NOTCH; s++) begin
			write_reg(GAIN_REG[s], 32'h7FFF_FFFF);
			write_reg(COS_REG[s], 32'h8000_0000);
		end
		send_sample(12'hFFF, 32'd20);
		send_sample(12'hFFF, 32'd21);
		send_sample(12'd0, 32'd22);
		send_sample(12'd0, 32'd23);
		wait_for_idle();
		for (int s = 0; s < NUM_NOTCH; s++) begin
			write_reg(GAIN_REG[s], 32'h8000_0000);
			write_reg(COS_REG[s], 32'h7FFF_FFFF);
		end
		send_sample(12'hFFF, 32'd24);
		send_sample(12'd0, 32'd25);
		wait_for_idle();
		// all-zero coefficients leave a2 at minus one
		for (int s = 0; s < NUM_NOTCH; s++) begin
			write_reg(GAIN_REG[s], 32'd0);
			write_reg(COS_REG[s], 32'd0);
		end
		send_sample(12'd2048, 32'd26);
		send_sample(12'hFFF, 32'd27);
		wait_for_idle();
		write_default_coefs();
	endtask

	// bursts of random samples with new settings between bursts
	task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
		input int n_items);
		int sent;
		int burst;
		sender_idle_pct = send_pct;
		receiver_idle_pct = recv_pct;
		sent = 0;
		while (sent < n_items) begin
			reprogram_random();
			burst = $urandom_range(50, 100);
			for (int i = 0; i < burst && sent < n_items; i++) begin
				send_sample(next_raw_sample(), next_index());
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// result checking, receiver stalls and the stall watchdog
	// ------------------------------------------------------------------

	always @(posedge clk) begin : result_check
		filtered_item_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			quiet_cycles = 0;
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("result %0d with no item pending: raw %0d filtered %0d index %0h",
						results_seen, results_ch.raw_out, results_ch.filtered_out,
						results_ch.index_out);
				end
			end else begin
				want = pending_results.pop_front();
				if (results_ch.raw_out !== want.raw || results_ch.filtered_out !== want.filtered ||
					results_ch.index_out !== want.index) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("result %0d mismatch: raw %0d/%0d filtered %0d/%0d index %0h/%0h",
							results_seen, want.raw, results_ch.raw_out, want.filtered,
							results_ch.filtered_out, want.index, results_ch.index_out);
					end
				end
			end
		end else if (arst_n && samples_ch.valid && samples_ch.ready) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
		results_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// ------------------------------------------------------------------
	// sequence of tests
	// ------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_CENTER_OFFSET;
		cfg_wdata = '0;
		samples_ch.valid = 1'b0;
		samples_ch.raw_sample = '0;
		samples_ch.sample_index = '0;
		sender_idle_pct = 13;
		receiver_idle_pct = 59;
		walk_level = 2048;
		sample_seq = '0;

		// predictor starts from the reset settings with empty delay lines
		cur_offset = CENTER_OFFSET_RST;
		for (int s = 0; s < NUM_NOTCH; s++) begin
			cur_gain[s] = GAIN_RST[s];
			cur_cos[s] = COS_RST[s];
			section_z1[s] = 0;
			section_z2[s] = 0;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_extremes();
		test_offset_range();
		test_coef_extremes();

		// sender idles little and receiver often, then the reverse, then no idling
		test_random_traffic(13, 59, 620);
		test_random_traffic(59, 13, 620);
		test_random_traffic(0, 0, 620);

		wait_for_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
